// ===== design/brc_pkg.sv =====
package brc_pkg;

	localparam int COORD_W   = 11;
	localparam int VALUE_W   = 8;
	localparam int COUNT_W   = 23;
	localparam int SUM_W     = 34;
	localparam int CFG_IDX_W = 8;
	localparam int MAX_DIM_DEF = 2048;
	localparam int QUEUE_DEPTH = 2;
	localparam int STEP_W    = $clog2(COORD_W);

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP    = 8'd0,
		REG_BOTTOM = 8'd1,
		REG_LEFT   = 8'd2,
		REG_RIGHT  = 8'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} back_state_t;

	// one finished frame, waiting to be divided out
	typedef struct packed {
		logic [SUM_W-1:0]   row_sum;
		logic [SUM_W-1:0]   col_sum;
		logic [COUNT_W-1:0] count;
		logic [COORD_W-1:0] mid_row;
		logic [COORD_W-1:0] mid_col;
	} job_t;

endpackage

// ===== design/brc_front.sv =====
module brc_front #(
	parameter int MAX_DIM = brc_pkg::MAX_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [brc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brc_pkg::COORD_W-1:0]     cfg_data,
	input  logic                            pix_valid,
	output logic                            pix_ready,
	input  logic [brc_pkg::COORD_W-1:0]     pixel_row,
	input  logic [brc_pkg::COORD_W-1:0]     pixel_col,
	input  logic [brc_pkg::VALUE_W-1:0]     pixel_value,
	input  logic                            frame_last,
	input  logic                            q_full,
	output logic                            q_push,
	output brc_pkg::job_t                   q_job
);

	logic [brc_pkg::COORD_W-1:0] top_q, bottom_q, left_q, right_q;
	logic [brc_pkg::SUM_W-1:0]   row_sum_q, col_sum_q;
	logic [brc_pkg::COUNT_W-1:0] count_q;

	logic                        accept;
	logic                        row_in, col_in, take;
	logic [brc_pkg::SUM_W-1:0]   row_sum_n, col_sum_n;
	logic [brc_pkg::COUNT_W-1:0] count_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			bottom_q <= brc_pkg::COORD_MAX;
			left_q   <= '0;
			right_q  <= brc_pkg::COORD_MAX;
		end else if (cfg_valid) begin
			case (brc_pkg::cfg_reg_t'(cfg_index))
				brc_pkg::REG_TOP:    top_q    <= cfg_data;
				brc_pkg::REG_BOTTOM: bottom_q <= cfg_data;
				brc_pkg::REG_LEFT:   left_q   <= cfg_data;
				brc_pkg::REG_RIGHT:  right_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pix_ready = !q_full;
	assign accept    = pix_valid && pix_ready;

	// keep lo+1 <= pos < hi-1, one-pixel border trimmed
	assign row_in = (pixel_row > top_q)
		&& ({1'b0, pixel_row} + 12'd1 < {1'b0, bottom_q})
		&& (32'(pixel_row) < MAX_DIM);
	assign col_in = (pixel_col > left_q)
		&& ({1'b0, pixel_col} + 12'd1 < {1'b0, right_q})
		&& (32'(pixel_col) < MAX_DIM);
	assign take = (pixel_value == '0) && (count_q != brc_pkg::COUNT_MAX) && row_in && col_in;

	always_comb begin
		row_sum_n = row_sum_q;
		col_sum_n = col_sum_q;
		count_n   = count_q;
		if (take) begin
			row_sum_n = row_sum_q + brc_pkg::SUM_W'(pixel_row);
			col_sum_n = col_sum_q + brc_pkg::SUM_W'(pixel_col);
			count_n   = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
			col_sum_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (frame_last) begin
				row_sum_q <= '0;
				col_sum_q <= '0;
				count_q   <= '0;
			end else begin
				row_sum_q <= row_sum_n;
				col_sum_q <= col_sum_n;
				count_q   <= count_n;
			end
		end
	end

	assign q_push          = accept && frame_last;
	assign q_job.row_sum   = row_sum_n;
	assign q_job.col_sum   = col_sum_n;
	assign q_job.count     = count_n;
	assign q_job.mid_row   = brc_pkg::COORD_W'(({1'b0, bottom_q} + {1'b0, top_q}) >> 1);
	assign q_job.mid_col   = brc_pkg::COORD_W'(({1'b0, left_q} + {1'b0, right_q}) >> 1);

endmodule

// ===== design/brc_queue.sv =====
module brc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  brc_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output brc_pkg::job_t pop_job,
	output logic          empty
);

	localparam int PTR_W = $clog2(brc_pkg::QUEUE_DEPTH);

	brc_pkg::job_t   slot_q [brc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   fill_q;

	assign full    = (fill_q == (PTR_W+1)'(brc_pkg::QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(brc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop && !empty)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(brc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			fill_q <= fill_q + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && !empty);
		end
	end

endmodule

// ===== design/brc_back.sv =====
module brc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  brc_pkg::job_t                 q_job,
	output logic                          q_pop,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [brc_pkg::COORD_W-1:0]   centroid_row,
	output logic [brc_pkg::COORD_W-1:0]   centroid_col,
	output logic [brc_pkg::COUNT_W-1:0]   black_count,
	output logic                          region_empty
);

	brc_pkg::back_state_t state_q, state_n;

	logic [brc_pkg::SUM_W-1:0]   rem_row_q, rem_col_q;
	logic [brc_pkg::COUNT_W-1:0] divisor_q;
	logic [brc_pkg::STEP_W-1:0]  step_q;
	logic [brc_pkg::COORD_W-1:0] quo_row_q, quo_col_q;
	logic                        empty_q;

	logic [brc_pkg::SUM_W-1:0]   div_shift;
	logic                        row_fit, col_fit;
	logic                        load;

	// restoring division; quotient never exceeds a coordinate, so COORD_W steps
	assign div_shift = brc_pkg::SUM_W'(divisor_q) << step_q;
	assign row_fit   = rem_row_q >= div_shift;
	assign col_fit   = rem_col_q >= div_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= brc_pkg::ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n   = state_q;
		q_pop     = 1'b0;
		load      = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			brc_pkg::ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					load    = 1'b1;
					state_n = (q_job.count == '0) ? brc_pkg::ST_OUT : brc_pkg::ST_DIV;
				end
			end
			brc_pkg::ST_DIV: begin
				if (step_q == '0)
					state_n = brc_pkg::ST_OUT;
			end
			brc_pkg::ST_OUT: begin
				res_valid = 1'b1;
				if (res_ready)
					state_n = brc_pkg::ST_IDLE;
			end
			default: state_n = brc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_row_q <= q_job.row_sum;
			rem_col_q <= q_job.col_sum;
			divisor_q <= q_job.count;
			step_q    <= brc_pkg::STEP_W'(brc_pkg::COORD_W - 1);
			quo_row_q <= q_job.mid_row;
			quo_col_q <= q_job.mid_col;
			empty_q   <= (q_job.count == '0);
		end else if (state_q == brc_pkg::ST_DIV) begin
			if (row_fit)
				rem_row_q <= rem_row_q - div_shift;
			if (col_fit)
				rem_col_q <= rem_col_q - div_shift;
			quo_row_q <= {quo_row_q[brc_pkg::COORD_W-2:0], row_fit};
			quo_col_q <= {quo_col_q[brc_pkg::COORD_W-2:0], col_fit};
			step_q    <= step_q - 1'b1;
		end
	end

	assign centroid_row = quo_row_q;
	assign centroid_col = quo_col_q;
	assign black_count  = divisor_q;
	assign region_empty = empty_q;

endmodule

// ===== design/binary_region_centroid.sv =====
// Pixels: one accepted per cycle; pix_ready drops only while the frame queue is full.
// After the frame's last pixel, its job is queued, popped by the idle back end, run
// through the 11-step shared restoring divider and offered; an empty region skips it.
// Back end: one frame at a time, popped only when idle, so a new frame waits until the
// last result is taken; a 2-entry queue holds finished frames meanwhile.
// Reset: rectangle set to the full 2048x2048 frame, sums and count cleared, queue empty.
module binary_region_centroid #(
	parameter int MAX_DIM = brc_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [brc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [brc_pkg::COORD_W-1:0]   cfg_data,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  logic [brc_pkg::COORD_W-1:0]   pixel_row,
	input  logic [brc_pkg::COORD_W-1:0]   pixel_col,
	input  logic [brc_pkg::VALUE_W-1:0]   pixel_value,
	input  logic                          frame_last,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [brc_pkg::COORD_W-1:0]   centroid_row,
	output logic [brc_pkg::COORD_W-1:0]   centroid_col,
	output logic [brc_pkg::COUNT_W-1:0]   black_count,
	output logic                          region_empty
);

	logic          q_push, q_full, q_pop, q_empty;
	brc_pkg::job_t push_job, pop_job;

	assign cfg_ready = 1'b1;

	brc_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.pixel_value (pixel_value),
		.frame_last  (frame_last),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	brc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	brc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_job        (pop_job),
		.q_pop        (q_pop),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.centroid_row (centroid_row),
		.centroid_col (centroid_col),
		.black_count  (black_count),
		.region_empty (region_empty)
	);

endmodule
